// ===== design/msr_pkg.sv =====
// Shared constants, types and helpers of the maximum-sum rectangle search.
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

  localparam int Cols     = 8;
  localparam int MaxRows  = 16;
  localparam int Capacity = Cols * MaxRows;

  localparam int AddrW   = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int ColW    = (Cols > 1) ? $clog2(Cols) : 1;
  localparam int CcntW   = $clog2(Cols + 1);
  localparam int RcntW   = $clog2(MaxRows + 1);
  localparam int SampleW = 16;
  localparam int AccW    = SampleW + ((MaxRows > 1) ? $clog2(MaxRows) : 0);
  localparam int SumW    = AccW + ((Cols > 1) ? $clog2(Cols) : 0);
  localparam int OutSumW = 23;
  localparam int OutDataW = 40;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  localparam logic [CcntW-1:0] ColsC    = CcntW'(Cols);
  localparam logic [RcntW-1:0] MaxRowsC = RcntW'(MaxRows);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSearchMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAnchorRow  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAnchorCol  = 2'd2;

  // result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusOverflow = 2'd1;
  localparam logic [1:0] StatusEmpty    = 2'd2;

  typedef enum logic [1:0] {
    StLoad,
    StStart,
    StSearch
  } state_e;

  // one candidate rectangle, aligned with the table read data
  typedef struct packed {
    logic             valid;
    logic [RcntW-1:0] t;
    logic [CcntW-1:0] l;
    logic [RcntW-1:0] b;
    logic [CcntW-1:0] rr;
    logic             clr_col;
    logic             clr_run;
    logic             first;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic                      valid;
    logic [RcntW-1:0]          t;
    logic [CcntW-1:0]          l;
    logic [RcntW-1:0]          b;
    logic [CcntW-1:0]          rr;
    logic signed [OutSumW-1:0] sum;
  } result_t;

  localparam int SatW = (SumW > OutSumW) ? SumW : OutSumW;

  function automatic logic signed [OutSumW-1:0] sat_sum(input logic signed [SumW-1:0] v);
    logic signed [SatW-1:0] w;
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    w  = SatW'(v);
    hi = SatW'({1'b0, {(OutSumW - 1){1'b1}}});
    lo = -hi - SatW'(1);
    if (w > hi) begin
      w = hi;
    end else if (w < lo) begin
      w = lo;
    end
    return OutSumW'(w);
  endfunction

endpackage

`default_nettype wire

// ===== design/msr_table_mem.sv =====
// Table store: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none

module msr_table_mem (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [msr_pkg::AddrW-1:0]       wr_addr_i,
  input  wire logic [msr_pkg::SampleW-1:0]     wr_data_i,
  input  wire logic                            rd_en_i,
  input  wire logic [msr_pkg::AddrW-1:0]       rd_addr_i,
  output logic      [msr_pkg::SampleW-1:0]     rd_data_o
);

  logic [msr_pkg::SampleW-1:0] mem [msr_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/msr_scan.sv =====
// Candidate sequencer: walks corners in scan order, one table read a cycle.
`timescale 1ns / 1ps
`default_nettype none

module msr_scan (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic                      mode_i,
  input  wire logic [3:0]                anchor_row_i,
  input  wire logic [2:0]                anchor_col_i,
  input  wire logic [msr_pkg::RcntW-1:0] rows_i,
  output logic                           rd_en_o,
  output logic [msr_pkg::AddrW-1:0]      rd_addr_o,
  output msr_pkg::tag_t                  tag_o
);

  logic                      busy_q, busy_d;
  logic                      first_q, first_d;
  logic [msr_pkg::RcntW-1:0] t_q, t_d, b_q, b_d, t1_q, t1_d;
  logic [msr_pkg::CcntW-1:0] l_q, l_d, rr_q, rr_d, l0_q, l0_d, l1_q, l1_d;
  logic                      col_end, row_end, l_end, t_end, last_cand;
  msr_pkg::tag_t             tag_d, tag_q;

  assign col_end   = (rr_q == msr_pkg::ColsC - 1'b1);
  assign row_end   = (b_q == rows_i - 1'b1);
  assign l_end     = (l_q == l1_q - 1'b1);
  assign t_end     = (t_q == t1_q - 1'b1);
  assign last_cand = col_end && row_end && l_end && t_end;

  assign rd_en_o   = busy_q;
  assign rd_addr_o = msr_pkg::AddrW'(b_q * msr_pkg::Cols + rr_q);

  always_comb begin
    tag_d         = '0;
    tag_d.valid   = busy_q;
    tag_d.t       = t_q;
    tag_d.l       = l_q;
    tag_d.b       = b_q;
    tag_d.rr      = rr_q;
    tag_d.clr_col = (b_q == t_q);
    tag_d.clr_run = (rr_q == l_q);
    tag_d.first   = first_q;
    tag_d.last    = last_cand;
  end

  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    t_d     = t_q;
    l_d     = l_q;
    b_d     = b_q;
    rr_d    = rr_q;
    t1_d    = t1_q;
    l0_d    = l0_q;
    l1_d    = l1_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      if (mode_i) begin
        t_d  = '0;
        t1_d = rows_i;
        l0_d = '0;
        l1_d = msr_pkg::ColsC;
      end else begin
        t_d  = msr_pkg::RcntW'(anchor_row_i);
        t1_d = msr_pkg::RcntW'(anchor_row_i) + 1'b1;
        l0_d = msr_pkg::CcntW'(anchor_col_i);
        l1_d = msr_pkg::CcntW'(anchor_col_i) + 1'b1;
      end
      l_d  = l0_d;
      b_d  = t_d;
      rr_d = l0_d;
    end else if (busy_q) begin
      first_d = 1'b0;
      // advance innermost first: right column, bottom row, left column, top row
      priority if (!col_end) begin
        rr_d = rr_q + 1'b1;
      end else if (!row_end) begin
        b_d  = b_q + 1'b1;
        rr_d = l_q;
      end else if (!l_end) begin
        l_d  = l_q + 1'b1;
        b_d  = t_q;
        rr_d = l_q + 1'b1;
      end else if (!t_end) begin
        t_d  = t_q + 1'b1;
        l_d  = l0_q;
        b_d  = t_q + 1'b1;
        rr_d = l0_q;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      tag_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      first_q <= first_d;
      tag_q   <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    l_q  <= l_d;
    b_q  <= b_d;
    rr_q <= rr_d;
    t1_q <= t1_d;
    l0_q <= l0_d;
    l1_q <= l1_d;
  end

  assign tag_o = tag_q;

endmodule

`default_nettype wire

// ===== design/msr_accum.sv =====
// Column accumulators, running rectangle sum and best-candidate tracking.
`timescale 1ns / 1ps
`default_nettype none

module msr_accum (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire msr_pkg::tag_t               tag_i,
  input  wire logic [msr_pkg::SampleW-1:0] rd_data_i,
  output msr_pkg::result_t                 res_o
);

  logic signed [msr_pkg::AccW-1:0] colacc_q [msr_pkg::Cols];
  logic signed [msr_pkg::AccW-1:0] sample_ext, acc_old, acc_new;
  logic signed [msr_pkg::SumW-1:0] run_q, run_old, run_new;
  logic signed [msr_pkg::SumW-1:0] best_q;
  logic [msr_pkg::ColW-1:0]        idx;

  logic                      s2_valid_q, s2_first_q, s2_last_q, res_valid_q, better;
  logic [msr_pkg::RcntW-1:0] s2_t_q, s2_b_q, bt_q, bb_q;
  logic [msr_pkg::CcntW-1:0] s2_l_q, s2_rr_q, bl_q, br_q;

  assign idx = tag_i.rr[msr_pkg::ColW-1:0];

  // column sum over rows top..bottom, then running sum over columns left..right
  always_comb begin
    sample_ext = msr_pkg::AccW'($signed(rd_data_i));
    acc_old    = tag_i.clr_col ? '0 : colacc_q[idx];
    acc_new    = acc_old + sample_ext;
    run_old    = tag_i.clr_run ? '0 : run_q;
    run_new    = run_old + msr_pkg::SumW'(acc_new);
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.valid) begin
      colacc_q[idx] <= acc_new;
      run_q         <= run_new;
    end
    s2_t_q  <= tag_i.t;
    s2_l_q  <= tag_i.l;
    s2_b_q  <= tag_i.b;
    s2_rr_q <= tag_i.rr;
    s2_first_q <= tag_i.first;
    s2_last_q  <= tag_i.last;
  end

  // strict compare keeps the earliest best in scan order
  assign better = s2_first_q || (run_q > best_q);

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && better) begin
      best_q <= run_q;
      bt_q   <= s2_t_q;
      bl_q   <= s2_l_q;
      bb_q   <= s2_b_q;
      br_q   <= s2_rr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= tag_i.valid;
      res_valid_q <= s2_valid_q && s2_last_q;
    end
  end

  always_comb begin
    res_o       = '0;
    res_o.valid = res_valid_q;
    res_o.t     = bt_q;
    res_o.l     = bl_q;
    res_o.b     = bb_q;
    res_o.rr    = br_q;
    res_o.sum   = msr_pkg::sat_sum(best_q);
  end

endmodule

`default_nettype wire

// ===== design/max_sum_rectangle_search.sv =====
// Top level of the maximum-sum rectangle search: load control, config and output register.
//
// Samples stream in row-major order, Cols per row, one transfer per cycle while tready is
// high, and are written straight into the table memory; tlast closes the table. Only complete
// rows count, and samples beyond MaxRows rows are dropped and flagged with status 1. After
// tlast the block stops taking samples, waits until any earlier result has been
// transferred, and then scans candidate rectangles: one table read per candidate through
// the memory's single read port, so a search over R rows reads R*(R+1)/2 * Cols*(Cols+1)/2
// candidates in full mode (4896 for a full 16x8 table) and (R-anchor_row)*(Cols-anchor_col)
// in anchored mode. An empty table or an anchor outside the table yields status 2 with
// zero corners and sum. While the result waits in the output register the next table
// already loads.
// Write configuration only between tables.
`timescale 1ns / 1ps
`default_nettype none

module max_sum_rectangle_search (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [msr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [msr_pkg::CfgDataW-1:0]   cfg_data_i,
  // sample stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [15:0]                    s_axis_tdata,   // [15:0] sample_value
  input  wire logic                           s_axis_tlast,   // last_element
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [3:0] top_row, [6:4] left_col, [10:7] bottom_row, [13:11] right_col,
  // [36:14] best_sum, [38:37] status, [39] zero
  output logic [msr_pkg::OutDataW-1:0]        m_axis_tdata
);

  // configuration registers
  logic       search_mode_q;
  logic [3:0] anchor_row_q;
  logic [2:0] anchor_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_mode_q <= 1'b1;
      anchor_row_q  <= '0;
      anchor_col_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msr_pkg::CfgSearchMode: search_mode_q <= cfg_data_i[0];
        msr_pkg::CfgAnchorRow:  anchor_row_q  <= cfg_data_i[3:0];
        msr_pkg::CfgAnchorCol:  anchor_col_q  <= cfg_data_i[2:0];
        default: ;  // no register at this index: drop the write
      endcase
    end
  end

  msr_pkg::state_e state_q, state_d;

  logic                      in_xfer, full, bad;
  logic                      start_search, emit_empty;
  logic                      mem_we;
  logic [msr_pkg::AddrW-1:0] load_addr_q;
  logic [msr_pkg::CcntW-1:0] col_cnt_q, col_cnt_d;
  logic [msr_pkg::RcntW-1:0] row_cnt_q, row_cnt_d;
  logic [msr_pkg::RcntW-1:0] rows_q;
  logic                      ovf_q, tab_ovf_q;

  logic                      rd_en;
  logic [msr_pkg::AddrW-1:0] rd_addr;
  logic [msr_pkg::SampleW-1:0] rd_data;
  msr_pkg::tag_t             tag;
  msr_pkg::result_t          res;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign full    = (row_cnt_q == msr_pkg::MaxRowsC);
  assign mem_we  = in_xfer && !full;

  // count the position of the next sample; a row completes on its last column
  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (mem_we) begin
      if (col_cnt_q == msr_pkg::ColsC - 1'b1) begin
        col_cnt_d = '0;
        row_cnt_d = row_cnt_q + 1'b1;
      end else begin
        col_cnt_d = col_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_addr_q <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      ovf_q       <= 1'b0;
    end else if (in_xfer && s_axis_tlast) begin
      load_addr_q <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      ovf_q       <= 1'b0;
    end else if (in_xfer) begin
      if (mem_we) begin
        load_addr_q <= load_addr_q + 1'b1;
      end
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      ovf_q     <= ovf_q || full;
    end
  end

  // latch the shape of the closed table; held for the whole search
  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast) begin
      rows_q    <= row_cnt_d;
      tab_ovf_q <= ovf_q || full;
    end
  end

  assign bad = (rows_q == '0) ||
               (!search_mode_q && ((anchor_row_q >= rows_q) ||
                                   (anchor_col_q >= msr_pkg::ColsC)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msr_pkg::StLoad: begin
        if (in_xfer && s_axis_tlast) begin
          state_d = msr_pkg::StStart;
        end
      end
      msr_pkg::StStart: begin
        if (!m_axis_tvalid) begin
          state_d = bad ? msr_pkg::StLoad : msr_pkg::StSearch;
        end
      end
      msr_pkg::StSearch: begin
        if (res.valid) begin
          state_d = msr_pkg::StLoad;
        end
      end
      default: state_d = msr_pkg::StLoad;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    start_search  = 1'b0;
    emit_empty    = 1'b0;
    unique case (state_q)
      msr_pkg::StLoad:   s_axis_tready = 1'b1;
      msr_pkg::StStart: begin
        start_search = !m_axis_tvalid && !bad;
        emit_empty   = !m_axis_tvalid && bad;
      end
      msr_pkg::StSearch: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msr_pkg::StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  msr_table_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wr_addr_i (load_addr_q),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  msr_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_search),
    .mode_i       (search_mode_q),
    .anchor_row_i (anchor_row_q),
    .anchor_col_i (anchor_col_q),
    .rows_i       (rows_q),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .tag_o        (tag)
  );

  msr_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag),
    .rd_data_i (rd_data),
    .res_o     (res)
  );

  // output register: hold the result until the transfer completes
  logic                              out_valid_q;
  logic [3:0]                        out_top_q, out_bottom_q;
  logic [2:0]                        out_left_q, out_right_q;
  logic signed [msr_pkg::OutSumW-1:0] out_sum_q;
  logic [1:0]                        out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid || emit_empty) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_empty) begin
      out_top_q    <= '0;
      out_left_q   <= '0;
      out_bottom_q <= '0;
      out_right_q  <= '0;
      out_sum_q    <= '0;
      out_status_q <= msr_pkg::StatusEmpty;
    end else if (res.valid) begin
      out_top_q    <= 4'(res.t);
      out_left_q   <= 3'(res.l);
      out_bottom_q <= 4'(res.b);
      out_right_q  <= 3'(res.rr);
      out_sum_q    <= res.sum;
      out_status_q <= tab_ovf_q ? msr_pkg::StatusOverflow : msr_pkg::StatusOk;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_status_q, out_sum_q, out_right_q, out_bottom_q,
                          out_left_q, out_top_q};

  // a finished search never lands on a result still waiting for transfer
  a_res_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !out_valid_q)
    else $error("search result collides with pending output");

  // a search only starts on a table with at least one complete row
  a_start_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_search |-> (rows_q != '0))
    else $error("search started on empty table");

  // the stored row count never exceeds capacity
  a_row_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q <= msr_pkg::MaxRowsC)
    else $error("row count beyond capacity");

  // no candidate reads are in flight while samples load
  a_no_scan_in_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msr_pkg::StLoad) |-> (!tag.valid && !rd_en))
    else $error("table read during load");

  // the memory is never written and read in the same cycle
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && rd_en))
    else $error("table write overlaps search read");

endmodule

`default_nettype wire

// ===== sim/msr_result_checker.sv =====
// Result checker for the maximum-sum rectangle search: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none

module msr_result_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [msr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [msr_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  input  wire logic                         s_axis_tready,
  input  wire logic [15:0]                  s_axis_tdata,   // [15:0] sample_value
  input  wire logic                         s_axis_tlast,   // last_element
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [3:0] top_row, [6:4] left_col, [10:7] bottom_row, [13:11] right_col,
  // [36:14] best_sum, [38:37] status, [39] zero
  input  wire logic [msr_pkg::OutDataW-1:0] m_axis_tdata,
  output int                                mismatches_o,
  output int                                results_o,
  output int                                pending_o,
  output int                                n_ok_o,
  output int                                n_dropped_o,
  output int                                n_empty_o
);

  localparam int NCols = msr_pkg::Cols;
  localparam int NRows = msr_pkg::MaxRows;
  localparam longint SumHi = (longint'(1) <<< (msr_pkg::OutSumW - 1)) - 1;
  localparam longint SumLo = -(longint'(1) <<< (msr_pkg::OutSumW - 1));

  // result layout, lowest field last
  typedef struct packed {
    logic               pad;
    logic [1:0]         status;
    logic signed [22:0] sum;
    logic [2:0]         right_col;
    logic [3:0]         bottom_row;
    logic [2:0]         left_col;
    logic [3:0]         top_row;
  } rect_result_t;

  logic [15:0]  table_mem [msr_pkg::Capacity];
  int           fill_cnt;
  logic         rows_dropped;
  logic         all_corners;
  logic [3:0]   anchor_row;
  logic [2:0]   anchor_col;
  rect_result_t expected_rects [$];

  // exhaustive search over the complete rows of the current table, from the anchor in anchored mode
  function automatic rect_result_t best_rectangle();
    longint       psum [0:NRows][0:NCols];
    rect_result_t res;
    int           rows, t0, t1, l0, l1, t, l, b, rc;
    longint       best, s;
    res = '0;
    rows = fill_cnt / NCols;
    res.status = rows_dropped ? msr_pkg::StatusOverflow : msr_pkg::StatusOk;
    if (rows == 0 || (!all_corners &&
        (int'(anchor_row) >= rows || int'(anchor_col) >= NCols))) begin
      res.status = msr_pkg::StatusEmpty;
      return res;
    end
    for (t = 0; t <= rows; t++) begin
      for (l = 0; l <= NCols; l++) begin
        if (t == 0 || l == 0) begin
          psum[t][l] = 0;
        end else begin
          psum[t][l] = psum[t-1][l] + psum[t][l-1] - psum[t-1][l-1]
                       + longint'($signed(table_mem[(t-1)*NCols + l-1]));
        end
      end
    end
    if (all_corners) begin
      t0 = 0; t1 = rows; l0 = 0; l1 = NCols;
    end else begin
      t0 = anchor_row; t1 = t0 + 1; l0 = anchor_col; l1 = l0 + 1;
    end
    res.top_row = 4'(t0);
    res.left_col = 3'(l0);
    res.bottom_row = 4'(t0);
    res.right_col = 3'(l0);
    best = psum[t0+1][l0+1] - psum[t0][l0+1] - psum[t0+1][l0] + psum[t0][l0];
    for (t = t0; t < t1; t++) begin
      for (l = l0; l < l1; l++) begin
        for (b = t; b < rows; b++) begin
          for (rc = l; rc < NCols; rc++) begin
            s = psum[b+1][rc+1] - psum[t][rc+1] - psum[b+1][l] + psum[t][l];
            // strict compare keeps the first best in scan order
            if (s > best) begin
              best = s;
              res.top_row = 4'(t);
              res.left_col = 3'(l);
              res.bottom_row = 4'(b);
              res.right_col = 3'(rc);
            end
          end
        end
      end
    end
    if (best > SumHi) best = SumHi;
    if (best < SumLo) best = SumLo;
    res.sum = 23'(best);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rect_result_t got, want;
    if (!rst_ni) begin
      fill_cnt = 0;
      rows_dropped = 1'b0;
      all_corners = 1'b1;
      anchor_row = '0;
      anchor_col = '0;
      expected_rects.delete();
      mismatches_o = 0;
      results_o = 0;
      pending_o = 0;
      n_ok_o = 0;
      n_dropped_o = 0;
      n_empty_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          msr_pkg::CfgSearchMode: all_corners = cfg_data_i[0];
          msr_pkg::CfgAnchorRow:  anchor_row = cfg_data_i[3:0];
          msr_pkg::CfgAnchorCol:  anchor_col = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (fill_cnt < msr_pkg::Capacity) begin
          table_mem[fill_cnt] = s_axis_tdata;
          fill_cnt++;
        end else begin
          rows_dropped = 1'b1;
        end
        if (s_axis_tlast) begin
          expected_rects.push_back(best_rectangle());
          fill_cnt = 0;
          rows_dropped = 1'b0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = rect_result_t'(m_axis_tdata);
        results_o++;
        if (expected_rects.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("[%0t] result %h arrived with nothing pending", $realtime, m_axis_tdata);
        end else begin
          want = expected_rects.pop_front();
          case (want.status)
            msr_pkg::StatusOk:       n_ok_o++;
            msr_pkg::StatusOverflow: n_dropped_o++;
            default:                 n_empty_o++;
          endcase
          if (got.pad !== want.pad || got.status !== want.status || got.sum !== want.sum ||
              got.top_row !== want.top_row || got.left_col !== want.left_col ||
              got.bottom_row !== want.bottom_row || got.right_col !== want.right_col) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("[%0t] result %0d: expected (%0d,%0d)-(%0d,%0d) sum %0d status %0d pad %0b",
                       $realtime, results_o, want.top_row, want.left_col, want.bottom_row,
                       want.right_col, want.sum, want.status, want.pad);
              $display("             got      (%0d,%0d)-(%0d,%0d) sum %0d status %0d pad %0b",
                       got.top_row, got.left_col, got.bottom_row, got.right_col, got.sum,
                       got.status, got.pad);
            end
          end
        end
      end
      pending_o = expected_rects.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_max_sum_rectangle_search.sv =====
// Testbench top for the maximum-sum rectangle search: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_max_sum_rectangle_search;

  localparam int NCols = msr_pkg::Cols;
  localparam int NRows = msr_pkg::MaxRows;
  localparam int NItems = 1700;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [msr_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [msr_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata = '0;   // [15:0] sample_value
  logic                         s_axis_tlast = 1'b0; // last_element
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // [3:0] top_row, [6:4] left_col, [10:7] bottom_row, [13:11] right_col,
  // [36:14] best_sum, [38:37] status, [39] zero
  logic [msr_pkg::OutDataW-1:0] m_axis_tdata;

  int mismatches, results, pending, n_ok, n_dropped, n_empty;

  // stimulus bookkeeping
  int samples_sent = 0;
  int tables_sent = 0;
  int phases_run = 0;
  int burst_left = 0;

  // receiver pacing
  logic [15:0] rx_tick = '0;
  logic [1:0]  rx_mode = '0;

  always #5 clk_i = ~clk_i;

  max_sum_rectangle_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  msr_result_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatches),
    .results_o     (results),
    .pending_o     (pending),
    .n_ok_o        (n_ok),
    .n_dropped_o   (n_dropped),
    .n_empty_o     (n_empty)
  );

  // Receiver: pick a new random pacing mode whenever the low byte of the tick counter is zero:
  // always ready, coin flips, short ready windows or long stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_tick <= '0;
      rx_mode <= '0;
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 16'd1;
      if (rx_tick[7:0] == 8'd0) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_axis_tready <= (rx_tick[3:0] < 4'd3);
        default: m_axis_tready <= (rx_tick[5:0] >= 6'd40);
      endcase
    end
  end

  // Watchdog: the slowest legal run stays well below this.
  initial begin
    #20_000_000;
    $display("timeout: %0d of %0d tables answered", results, tables_sent);
    $display("FAILURE");
    $finish;
  end

  // Write one register; the caller drops the write enable after the group.
  task automatic cfg_write(input logic [msr_pkg::CfgIdxW-1:0] idx, input int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= msr_pkg::CfgDataW'(val);
    @(posedge clk_i);
  endtask

  // Write all three registers, then release the port.
  task automatic set_search(input int all_corners, input int arow, input int acol);
    cfg_write(msr_pkg::CfgSearchMode, all_corners);
    cfg_write(msr_pkg::CfgAnchorRow, arow);
    cfg_write(msr_pkg::CfgAnchorCol, acol);
    cfg_we_i <= 1'b0;
    phases_run++;
  endtask

  // Offer one sample and hold it until the transfer. At the end of a burst,
  // drop tvalid for a random gap; a zero gap extends the burst.
  task automatic push_sample(input logic [15:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_sent++;
    if (last) tables_sent++;
  endtask

  // Send a table of n samples, last one marked. Styles: plain random, extremes,
  // all negative (start element tends to win), all zero (ties), small values.
  task automatic send_table(input int n, input int style);
    int          i;
    logic [15:0] value;
    for (i = 0; i < n; i++) begin
      case (style)
        0, 1, 2, 3, 4: value = 16'($urandom);
        5: begin
          case ($urandom_range(0, 4))
            0:       value = 16'h8000;
            1:       value = 16'h7FFF;
            2:       value = 16'h0000;
            3:       value = 16'hFFFF;
            default: value = 16'h0001;
          endcase
        end
        6:       value = 16'(-$urandom_range(1, 32768));
        7:       value = 16'h0000;
        default: value = 16'($urandom_range(0, 200) - 100);
      endcase
      push_sample(value, i == n - 1);
    end
  endtask

  // Idle the source and wait until every table has its result, then let the
  // block settle before touching configuration.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results < tables_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] edge_row [8];
    int          arow, acol, all_corners, n_tables, k, rows, n, style, j, phase;
    edge_row = '{16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h0001};

    // Hold reset low, then release it at a clock edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset configuration (all corners).
    // A lone sample with tlast: no complete row, so an empty table.
    push_sample(16'h7FFF, 1'b1);
    // One row mixing both extremes.
    for (j = 0; j < NCols; j++) push_sample(edge_row[j], j == NCols - 1);
    // One zero row plus a partial row that must be ignored; ties keep (0,0).
    for (j = 0; j < NCols; j++) push_sample(16'h0000, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h7FFF, 1'b1);
    wait_idle();
    // Anchored mode with the anchor below a one-row table: anchor outside.
    set_search(0, 1, 7);
    for (j = 0; j < NCols; j++) push_sample(edge_row[j], j == NCols - 1);

    // Random phases: new settings, then a few tables per phase.
    phase = 0;
    while (samples_sent < NItems) begin
      wait_idle();
      case (phase)
        0:       begin all_corners = 0; arow = 0;  acol = 0; end
        1:       begin all_corners = 0; arow = 15; acol = 7; end
        2:       begin all_corners = 0; arow = 0;  acol = 7; end
        3:       begin all_corners = 0; arow = 15; acol = 0; end
        4:       begin all_corners = 1; arow = 15; acol = 7; end
        default: begin
          all_corners = $urandom_range(0, 1);
          arow = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
          acol = $urandom_range(0, 7);
        end
      endcase
      set_search(all_corners, arow, acol);
      phase++;
      n_tables = $urandom_range(1, 4);
      for (j = 0; j < n_tables && samples_sent < NItems; j++) begin
        k = $urandom_range(0, 99);
        style = $urandom_range(0, 9);
        if (all_corners == 0 && k < 60) begin
          // well-formed anchored table that reaches the anchor row
          rows = arow + 1 + $urandom_range(0, 2);
          if (rows > NRows) rows = NRows;
          n = rows * NCols;
          if (n < msr_pkg::Capacity && $urandom_range(0, 3) == 0)
            n += $urandom_range(1, NCols - 1);
        end else if (k < 4) begin
          n = msr_pkg::Capacity + $urandom_range(1, 20);   // rows beyond capacity
        end else if (k < 12) begin
          n = $urandom_range(1, NCols - 1);                // no complete row
        end else if (k < 18) begin
          n = msr_pkg::Capacity;                           // exactly full
        end else begin
          n = $urandom_range(1, 4) * NCols;
          if ($urandom_range(0, 3) == 0) n += $urandom_range(1, NCols - 1);
        end
        send_table(n, style);
      end
    end

    // Drain: every table answered, then a few more cycles for stray results.
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d samples in %0d tables over %0d settings of mode and anchor.",
             samples_sent, tables_sent, phases_run);
    $display("Results: %0d ok, %0d with rows dropped, %0d empty or anchor outside; %0d bad.",
             n_ok, n_dropped, n_empty, mismatches);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/msr_pkg.sv
design/msr_table_mem.sv
design/msr_scan.sv
design/msr_accum.sv
design/max_sum_rectangle_search.sv
sim/msr_result_checker.sv
sim/tb_max_sum_rectangle_search.sv
